/* rtl/text_console_writer_core_assert.svh */
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent checks on the top level; empty bodies when synthesising.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tcw: forbidden condition seen");
`define TCW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw: implication failed");
`else
`define TCW_ASSERT_NEVER(label, clk, rst, cond)
`define TCW_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OP_W        = 1;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  localparam logic [OP_W-1:0]   OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0]   OP_READ = 1'b1;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h1E;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h1E00;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_FEED    = 8'h0A;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [CHAR_W-1:0]      character;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [COL_FIELD_W-1:0] cursor_column;
    logic [ROW_FIELD_W-1:0] cursor_line;
    logic                   did_scroll;
    logic [CHAR_W-1:0]      cell_character;
    logic [ATTR_W-1:0]      cell_attribute;
  } tcw_out_t;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_BLANK  = 3'd1,
    CMD_RETURN = 3'd2,
    CMD_FEED   = 3'd3,
    CMD_PRINT  = 3'd4
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t              kind;
    logic [CHAR_W-1:0]      character;
    logic [ROW_FIELD_W-1:0] row;
    logic [COL_FIELD_W-1:0] col;
  } tcw_cmd_t;

endpackage

`default_nettype wire

/* rtl/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: ROWS x COLUMNS screen of character/attribute cells
// with a cursor, line wrap and scroll-up.
//
// Requests enter on in_valid/in_stall: op selects put (character) or cell
// read (read_row, read_col). Every request yields one result on
// out_valid/out_stall carrying the cursor after the request, the scroll
// flag and, for in-range reads, the cell. cfg_valid/cfg_ready writes the
// attribute byte; it is always ready.
// A two-entry request queue sits in front of the executing sequencer.
// A put is executed in S_RUN; a read passes S_RUN, then S_READ (registered
// RAM read). A put that scrolls then blanks the new bottom row in S_FILL;
// the screen is a ring of rows, so no row copy is needed.
// After reset the whole screen memory is swept to character 0 with
// attribute 0x1E, all ROWS * 2^clog2(COLUMNS) cells (3200 at 25 x 80),
// while in_stall stays high. When out_stall is held the result register
// keeps its request; the queue takes two more before in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire tcw_pkg::tcw_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output tcw_pkg::tcw_out_t                out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

`include "text_console_writer_core_assert.svh"

  logic [tcw_pkg::ATTR_W-1:0] attr;
  logic                       clearing;
  logic                       cmd_valid;
  logic                       cmd_pop;
  tcw_pkg::tcw_cmd_t          cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      attr <= cfg_data;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .attr      (attr),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `TCW_ASSERT_NEVER(a_no_result_while_clearing, clk, rst, out_valid && clearing)
  `TCW_ASSERT_IMPLIES(a_scroll_cursor, clk, rst, out_valid && out_data.did_scroll, (out_data.cursor_column == '0) && (out_data.cursor_line == tcw_pkg::ROW_FIELD_W'(ROWS - 1)))
  `TCW_ASSERT_IMPLIES(a_cursor_on_screen, clk, rst, out_valid, (out_data.cursor_column < tcw_pkg::COL_FIELD_W'(COLUMNS - 1) || out_data.cursor_column == tcw_pkg::COL_FIELD_W'(COLUMNS - 1)) && (out_data.cursor_line < tcw_pkg::ROW_FIELD_W'(ROWS - 1) || out_data.cursor_line == tcw_pkg::ROW_FIELD_W'(ROWS - 1)))
  `TCW_ASSERT_NEVER(a_no_pop_while_clearing, clk, rst, cmd_pop && clearing)

endmodule

`default_nettype wire

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tcw_pkg::tcw_in_t  in_data,
  input  wire logic              clearing,
  output logic                   cmd_valid,
  output tcw_pkg::tcw_cmd_t      cmd,
  input  wire logic              cmd_pop
);

  localparam logic [tcw_pkg::ROW_FIELD_W:0] ROWS_X =
    (tcw_pkg::ROW_FIELD_W + 1)'(ROWS);
  localparam logic [tcw_pkg::COL_FIELD_W:0] COLS_X =
    (tcw_pkg::COL_FIELD_W + 1)'(COLUMNS);

  tcw_pkg::tcw_cmd_t q [2];
  tcw_pkg::tcw_cmd_t cls;
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              in_range;

  assign in_range = ({1'b0, in_data.read_row} < ROWS_X) &&
                    ({1'b0, in_data.read_col} < COLS_X);

  always_comb begin
    cls.character = in_data.character;
    cls.row       = in_data.read_row;
    cls.col       = in_data.read_col;
    if (in_data.op == tcw_pkg::OP_READ) begin
      cls.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_BLANK;
    end else if (in_data.character == tcw_pkg::CH_RETURN) begin
      cls.kind = tcw_pkg::CMD_RETURN;
    end else if (in_data.character == tcw_pkg::CH_FEED) begin
      cls.kind = tcw_pkg::CMD_FEED;
    end else begin
      cls.kind = tcw_pkg::CMD_PRINT;
    end
  end

  assign in_stall  = (count == 2'd2) || clearing;
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued requests against the screen memory: cursor, scroll,
// bottom-row fill and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  input  wire tcw_pkg::tcw_cmd_t           cmd,
  output logic                             cmd_pop,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
  output logic                             clearing,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output tcw_pkg::tcw_out_t                out_data
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * (1 << COL_W);
  localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_RUN   = 4'b0010,
    S_READ  = 4'b0100,
    S_FILL  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [COL_W-1:0]           cur_x, cur_x_next;
  logic [ROW_W-1:0]           cur_y, cur_y_next;
  logic [ROW_W-1:0]           top, top_next;
  logic [ADDR_W-1:0]          clr_addr, clr_addr_next;
  logic [ROW_W-1:0]           fill_row, fill_row_next;
  logic [COL_W-1:0]           fill_col, fill_col_next;
  logic [tcw_pkg::ATTR_W-1:0] fill_attr, fill_attr_next;
  logic                       res_valid, res_valid_next;
  tcw_pkg::tcw_out_t          res, res_next;
  logic                       go;
  logic                       wrap;
  logic                       scroll;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= ROWS_X) begin
      sum = sum - ROWS_X;
    end
    return sum[ROW_W-1:0];
  endfunction

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign go        = cmd_valid && (!res_valid || !out_stall);
  assign ram_raddr = {phys_row(cmd.row[ROW_W-1:0], top), cmd.col[COL_W-1:0]};
  assign clearing  = (state == S_CLEAR);
  assign out_valid = res_valid;
  assign out_data  = res;

  always_comb begin
    state_next     = state;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    top_next       = top;
    clr_addr_next  = clr_addr;
    fill_row_next  = fill_row;
    fill_col_next  = fill_col;
    fill_attr_next = fill_attr;
    res_valid_next = res_valid && out_stall;
    res_next       = res;
    cmd_pop        = 1'b0;
    wrap           = 1'b0;
    scroll         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = clr_addr;
    ram_wdata      = tcw_pkg::RESET_CELL;

    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (go) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            tcw_pkg::CMD_READ:   state_next = S_READ;
            tcw_pkg::CMD_RETURN: cur_x_next = '0;
            tcw_pkg::CMD_FEED:   wrap = 1'b1;
            tcw_pkg::CMD_PRINT: begin
              ram_we    = 1'b1;
              ram_waddr = {phys_row(cur_y, top), cur_x};
              ram_wdata = {attr, cmd.character};
              if (cur_x == LAST_COL) begin
                wrap = 1'b1;
              end else begin
                cur_x_next = cur_x + 1'b1;
              end
            end
            default: ;
          endcase
          if (wrap) begin
            cur_x_next = '0;
            if (cur_y == LAST_ROW) begin
              scroll         = 1'b1;
              top_next       = (top == LAST_ROW) ? '0 : top + 1'b1;
              fill_row_next  = top;
              fill_col_next  = '0;
              fill_attr_next = attr;
              state_next     = S_FILL;
            end else begin
              cur_y_next = cur_y + 1'b1;
            end
          end
          if (cmd.kind != tcw_pkg::CMD_READ) begin
            res_valid_next          = 1'b1;
            res_next.cursor_column  = tcw_pkg::COL_FIELD_W'(cur_x_next);
            res_next.cursor_line    = tcw_pkg::ROW_FIELD_W'(cur_y_next);
            res_next.did_scroll     = scroll;
            res_next.cell_character = '0;
            res_next.cell_attribute = '0;
          end
        end
      end
      S_READ: begin
        res_valid_next          = 1'b1;
        res_next.cursor_column  = tcw_pkg::COL_FIELD_W'(cur_x);
        res_next.cursor_line    = tcw_pkg::ROW_FIELD_W'(cur_y);
        res_next.did_scroll     = 1'b0;
        res_next.cell_character = ram_rdata[tcw_pkg::CHAR_W-1:0];
        res_next.cell_attribute = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_next              = S_RUN;
      end
      S_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = {fill_row, fill_col};
        ram_wdata     = {fill_attr, tcw_pkg::CH_SPACE};
        fill_col_next = fill_col + 1'b1;
        if (fill_col == LAST_COL) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur_x     <= '0;
      cur_y     <= '0;
      top       <= '0;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_x     <= cur_x_next;
      cur_y     <= cur_y_next;
      top       <= top_next;
      clr_addr  <= clr_addr_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_row  <= fill_row_next;
    fill_col  <= fill_col_next;
    fill_attr <= fill_attr_next;
    res       <= res_next;
  end

endmodule

`default_nettype wire
